// ===== hdl/stg_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the sine tone generator.
// No dependencies; every other file in hdl/ imports this package.
package stg_pkg;

    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;   // must be a power of two

    localparam int NOTE_BITS    = 24;
    localparam int RATE_BITS    = 18;
    localparam int VOL_BITS     = 15;
    localparam int MAG_BITS     = 15;
    localparam int SAMPLE_BITS  = 16;
    localparam int CFG_BITS     = 18;

    localparam int IDX_BITS     = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_ADDR_W   = IDX_BITS + 1;
    localparam int DIV_STEPS    = NOTE_BITS + PHASE_BITS - 8;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
    localparam int MUL_CNT_W    = $clog2(MAG_BITS + 1);

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);
    localparam logic [VOL_BITS-1:0]  VOL_RESET  = VOL_BITS'(10000);

    // Configuration register indexes.
    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_VOLUME      = 1'b1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] HALF_Q30    = 64'd536870912;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;

    localparam int TAYLOR_DIV [0:6] = '{6, 20, 42, 72, 110, 156, 210};

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_HOLD
    } t_state;

    typedef logic [MAG_BITS-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    // Builds the table at elaboration: Taylor series through x^15 in Q2.30,
    // then rounded to Q1.15 and clamped.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            term = x;
            sum  = signed'(x);
            for (int k = 0; k < 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'(TAYLOR_DIV[k]);
                if ((k & 1) != 0) begin
                    sum = sum + signed'(term);
                end else begin
                    sum = sum - signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = ((unsigned'(sum) * FULL_SCALE) + HALF_Q30) >> 30;
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
            rom[i] = v[MAG_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ===== hdl/stg_in_if.sv =====
// Input channel of the sine tone generator: one sample tick word per handshake.
// Depends on stg_pkg for the field widths.
interface stg_in_if
    import stg_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [NOTE_BITS-1:0] note_hz;
    logic                 last_of_block;

    modport source (output valid, output note_hz, output last_of_block, input ready);
    modport sink   (input valid, input note_hz, input last_of_block, output ready);
endinterface

// ===== hdl/stg_out_if.sv =====
// Output channel of the sine tone generator: one stereo sample word per handshake.
// Depends on stg_pkg for the field widths.
interface stg_out_if
    import stg_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_out;

    modport source (output valid, output left_sample, output right_sample,
                    output last_out, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input last_out, output ready);
endinterface

// ===== hdl/stg_mul.sv =====
// Bit-serial shift-and-add multiplier: sine magnitude times volume, one bit a cycle.
// Depends on stg_pkg; gives the product shifted right by MAG_BITS.
module stg_mul
    import stg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MAG_BITS-1:0] i_mag,
    input  logic [VOL_BITS-1:0] i_vol,
    output logic [MAG_BITS-1:0] o_high
);

    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_BITS-1:0]  r_mag;
    logic [MAG_BITS-1:0]  r_hi, n_hi;
    logic [VOL_BITS-1:0]  r_lo, n_lo;
    logic [MAG_BITS:0]    sum;

    // The low register starts with the multiplier and fills with product bits.
    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mag} : {(MAG_BITS + 1){1'b0}});

    always_comb begin
        n_cnt = r_cnt;
        n_hi  = r_hi;
        n_lo  = r_lo;
        if (i_start) begin
            n_cnt = MUL_CNT_W'(VOL_BITS);
            n_hi  = '0;
            n_lo  = i_vol;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_hi  = sum[MAG_BITS:1];
            n_lo  = {sum[0], r_lo[VOL_BITS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
        end
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_high = r_hi;

endmodule

// ===== hdl/stg_div.sv =====
// Bit-serial restoring divider for the phase step: (note_hz << (PHASE_BITS-8)) / rate.
// Depends on stg_pkg; one quotient bit a cycle, low PHASE_BITS bits kept.
module stg_div
    import stg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NOTE_BITS-1:0]  i_num,
    input  logic [RATE_BITS-1:0]  i_den,
    output logic                  o_done,
    output logic [PHASE_BITS-1:0] o_quot
);

    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_done;
    logic [NOTE_BITS-1:0]  r_num;
    logic [RATE_BITS-1:0]  r_den;
    logic [RATE_BITS-1:0]  r_rem;
    logic [PHASE_BITS-1:0] r_quo;
    logic [RATE_BITS:0]    trial;
    logic [RATE_BITS:0]    diff;
    logic                  ge;

    assign trial = {r_rem, r_num[NOTE_BITS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Numerator bits leave MSB first; zeros follow for the fractional shift.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NOTE_BITS-2:0], 1'b0};
            r_rem <= ge ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
            r_quo <= {r_quo[PHASE_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    // A zero sample rate leaves the phase still.
    assign o_quot = (r_den == '0) ? '0 : r_quo;

endmodule

// ===== hdl/sine_tone_generator.sv =====
// Top level of the direct digital synthesis sine tone generator.
// Depends on stg_pkg, stg_in_if, stg_out_if, stg_mul and stg_div.
//
// Each input word is one sample tick carrying a frequency in unsigned Q16.8 hertz and
// a last-of-block mark. The block answers with one stereo word: the sine of the phase
// held before the tick, taken from a quarter-wave Q1.15 table with quadrant folding,
// scaled by the volume register and truncated toward zero, the same value on both
// channels, with the mark echoed. The phase then advances by note_hz / sample_rate of
// a turn, as a 32-bit fraction that wraps; a zero sample rate holds the phase still.
// The phase step comes from a bit-serial divider of NOTE_BITS + PHASE_BITS - 8 = 48
// steps, loaded on acceptance; no new tick is taken until it is done and the word has
// gone to the output register. The volume multiply runs bit-serially alongside the
// division and is hidden by it. The output register holds a finished word while the
// next tick is accepted; if it is still full when the following result is ready, the
// block waits. The user must write the registers through a plain write port (index 0
// sample_rate, index 1 volume) only while idle; the block itself does not enforce it.
module sine_tone_generator
    import stg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    stg_in_if.sink              i_in,
    stg_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [RATE_BITS-1:0]   r_rate;
    logic [VOL_BITS-1:0]    r_vol;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [MAG_BITS-1:0]    r_rom_q;
    logic                   r_accepted;
    logic                   r_neg;
    logic                   r_last;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_last;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic                   phase_load;
    logic                   in_ready;
    logic [IDX_BITS-1:0]    idx;
    logic [ROM_ADDR_W-1:0]  rom_addr;
    logic                   div_done;
    logic [PHASE_BITS-1:0]  step;
    logic [MAG_BITS-1:0]    scaled;
    logic [SAMPLE_BITS-1:0] sample;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_vol  <= VOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_RATE: r_rate <= i_cfg_data[RATE_BITS-1:0];
                CFG_VOLUME:      r_vol  <= i_cfg_data[VOL_BITS-1:0];
                default:         r_rate <= r_rate;
            endcase
        end
    end

    // Quadrant folding: odd quadrants read the table backwards. The table is read
    // every cycle from the held phase, so its output is ready when a tick arrives.
    assign idx      = r_phase[PHASE_BITS-3 -: IDX_BITS];
    assign rom_addr = r_phase[PHASE_BITS-2]
                    ? ROM_ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, idx}
                    : {1'b0, idx};

    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_ROM[rom_addr];
    end

    assign accept   = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    stg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_accepted),
        .i_mag   (r_rom_q),
        .i_vol   (r_vol),
        .o_high  (scaled)
    );

    stg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_in.note_hz),
        .i_den   (r_rate),
        .o_done  (div_done),
        .o_quot  (step)
    );

    // The lower half-turn gives a positive sample, the upper half its negation.
    assign sample = r_neg ? SAMPLE_BITS'(0) - {1'b0, scaled} : {1'b0, scaled};

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (div_done) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output decoding.
    always_comb begin
        in_ready   = 1'b0;
        out_load   = 1'b0;
        phase_load = 1'b0;
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_BUSY: begin
                phase_load = div_done;
                out_load   = div_done && out_free;
            end
            S_HOLD: out_load = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_accepted  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_accepted <= accept;
            if (phase_load) begin
                r_phase <= r_phase + step;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg  <= r_phase[PHASE_BITS-1];
            r_last <= i_in.last_of_block;
        end
        if (out_load) begin
            r_out_sample <= sample;
            r_out_last   <= r_last;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.left_sample  = r_out_sample;
    assign o_out.right_sample = r_out_sample;
    assign o_out.last_out     = r_out_last;

endmodule

// ===== hdl/stg_checker.sv =====
// Port-level checks for the sine tone generator, attached by the bind below.
// Depends on stg_pkg and on the ports of sine_tone_generator.
module stg_checker
    import stg_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_left,
    input logic signed [SAMPLE_BITS-1:0] i_right
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left))
        else $error("output word changed while stalled");

    // Both channels carry the same value.
    a_stereo_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_left == i_right)
        else $error("left and right channels differ");

    // One tick at a time: no second word is taken straight after the first.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input ready right after an accepted word");

    // The result needs the whole division, so an accepted word brings no early rise of the output valid.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 !$rose(i_out_valid))
        else $error("result appeared before the phase step could be known");

    // Samples stay inside the symmetric range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_left != 16'sh8000)
        else $error("sample outside the symmetric range");

endmodule

bind sine_tone_generator stg_checker u_stg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_left      (o_out.left_sample),
    .i_right     (o_out.right_sample)
);
